@@ rtl/tids_pkg.sv @@
// ----------------------------------------------------------------------------
// Tag ID history store package
// Request codes, item field widths and parameter defaults shared by the
// channel interfaces and the store.
// ----------------------------------------------------------------------------
package tids_pkg;

   // item field widths
   localparam int REQ_TYPE_W    = 3;
   localparam int TAG_ID_W      = 56;
   localparam int SLOT_SEL_W    = 2;
   localparam int ENTRY_SEL_W   = 2;
   localparam int FOUND_SLOT_W  = 2;
   localparam int FOUND_ENTRY_W = 2;

   // parameter defaults
   localparam int SLOTS_DEF   = 4;
   localparam int HISTORY_DEF = 4;
   localparam int ID_BITS_DEF = 56;

   // request kinds
   localparam logic [REQ_TYPE_W-1:0] REQ_SAVE       = 3'd0;
   localparam logic [REQ_TYPE_W-1:0] REQ_READ       = 3'd1;
   localparam logic [REQ_TYPE_W-1:0] REQ_MATCH_SLOT = 3'd2;
   localparam logic [REQ_TYPE_W-1:0] REQ_MATCH_ALL  = 3'd3;
   localparam logic [REQ_TYPE_W-1:0] REQ_CLEAR_SLOT = 3'd4;
   localparam logic [REQ_TYPE_W-1:0] REQ_CLEAR_ALL  = 3'd5;

endpackage

@@ rtl/tids_if.sv @@
// ----------------------------------------------------------------------------
// Tag ID history store channels
// Valid/ready channels for request items and result items.
// ----------------------------------------------------------------------------
interface tids_req_if;
   import tids_pkg::*;

   logic                   valid;
   logic                   ready;
   logic [REQ_TYPE_W-1:0]  req_type;
   logic [TAG_ID_W-1:0]    tag_id;
   logic                   tag_id_ok;
   logic [SLOT_SEL_W-1:0]  slot_sel;
   logic [ENTRY_SEL_W-1:0] entry_sel;

   modport source (output valid, req_type, tag_id, tag_id_ok, slot_sel, entry_sel,
                   input ready);
   modport sink   (input valid, req_type, tag_id, tag_id_ok, slot_sel, entry_sel,
                   output ready);
endinterface

interface tids_rsp_if;
   import tids_pkg::*;

   logic                     valid;
   logic                     ready;
   logic                     hit;
   logic [TAG_ID_W-1:0]      found_id;
   logic [FOUND_SLOT_W-1:0]  found_slot;
   logic [FOUND_ENTRY_W-1:0] found_entry;

   modport source (output valid, hit, found_id, found_slot, found_entry,
                   input ready);
   modport sink   (input valid, hit, found_id, found_slot, found_entry,
                   output ready);
endinterface

@@ rtl/tag_id_history_store.sv @@
// ----------------------------------------------------------------------------
// Tag ID history store
// Slotted table of tag IDs with a short history per slot: save, read, match
// in a slot, match across the table, clear a slot, clear the table.
// ----------------------------------------------------------------------------
// The IDs sit in one synchronous RAM of SLOTS*HISTORY words (one write port and
// one registered read port); valid bits sit in flip-flops, so reset and both
// clear requests take effect at once and no clearing pass runs.
// One request is worked at a time and the next is taken once its result is
// in the output register. Clear, unknown and out-of-range requests go straight
// to the result; a read issues one RAM read and takes its data; saves and
// matches scan the RAM, one entry per cycle on the read port, until a match or
// the last entry. A full-slot save then moves the history down one entry per
// cycle, reading through the same port, and writes the new ID last.
module tag_id_history_store #(
   parameter int SLOTS   = tids_pkg::SLOTS_DEF,
   parameter int HISTORY = tids_pkg::HISTORY_DEF,
   parameter int ID_BITS = tids_pkg::ID_BITS_DEF
) (
   input  logic        clock,
   input  logic        reset,
   tids_req_if.sink    req_chan,
   tids_rsp_if.source  rsp_chan
);
   import tids_pkg::*;

   localparam int TOTAL  = SLOTS * HISTORY;
   localparam int AW     = $clog2(TOTAL);
   localparam int SLOT_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
   localparam int ENT_W  = $clog2(HISTORY);

   localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(SLOTS - 1);
   localparam logic [ENT_W-1:0]  LAST_ENT  = ENT_W'(HISTORY - 1);

   // sequencer states
   localparam logic [2:0] ST_IDLE  = 3'd0;
   localparam logic [2:0] ST_SCAN  = 3'd1;
   localparam logic [2:0] ST_SHIFT = 3'd2;
   localparam logic [2:0] ST_STORE = 3'd3;
   localparam logic [2:0] ST_READ  = 3'd4;
   localparam logic [2:0] ST_RDATA = 3'd5;
   localparam logic [2:0] ST_DONE  = 3'd6;

   function automatic logic [AW-1:0] ent_addr(input logic [SLOT_W-1:0] s,
                                             input logic [ENT_W-1:0]  e);
      ent_addr = AW'(int'(s) * HISTORY + int'(e));
   endfunction

   // ID storage
   logic [ID_BITS-1:0] id_mem [TOTAL];
   logic [ID_BITS-1:0] q_ff;
   logic               rd_en;
   logic [AW-1:0]      rd_addr;
   logic               wr_en;
   logic [AW-1:0]      wr_addr;
   logic [ID_BITS-1:0] wr_data;

   // control state
   logic [2:0]         state_ff, state_in;
   logic [TOTAL-1:0]   valid_ff, valid_in;
   logic [SLOT_W-1:0]  is_slot_ff, is_slot_in;
   logic [ENT_W-1:0]   is_ent_ff, is_ent_in;
   logic               iss_more_ff, iss_more_in;
   logic               cmp_vld_ff, cmp_vld_in;
   logic [SLOT_W-1:0]  cmp_slot_ff, cmp_slot_in;
   logic [ENT_W-1:0]   cmp_ent_ff, cmp_ent_in;
   logic               free_fnd_ff, free_fnd_in;
   logic [ENT_W-1:0]   free_ent_ff, free_ent_in;
   logic [ENT_W-1:0]   st_ent_ff, st_ent_in;
   logic               rsp_valid_ff, rsp_valid_in;

   // request held for the duration of its work
   logic [REQ_TYPE_W-1:0] op_ff;
   logic [ID_BITS-1:0]    id_ff;
   logic [SLOT_W-1:0]     slot_ff;
   logic [ENT_W-1:0]      ent_ff;
   logic                  all_ff;

   // result being built, and the output register
   logic                     res_hit_ff, res_hit_in;
   logic [TAG_ID_W-1:0]      res_id_ff, res_id_in;
   logic [FOUND_SLOT_W-1:0]  res_slot_ff, res_slot_in;
   logic [FOUND_ENTRY_W-1:0] res_ent_ff, res_ent_in;
   logic                     rsp_load;
   logic                     rsp_hit_ff;
   logic [TAG_ID_W-1:0]      rsp_id_ff;
   logic [FOUND_SLOT_W-1:0]  rsp_slot_ff;
   logic [FOUND_ENTRY_W-1:0] rsp_ent_ff;

   logic               req_fire;
   logic               slot_ok;
   logic               ent_ok;
   logic [SLOT_W-1:0]  slot_new;
   logic [AW-1:0]      cmp_addr;
   logic               cmp_valid;
   logic               cmp_match;
   logic               cmp_last;
   logic               rd_valid;

   assign req_chan.ready = (state_ff == ST_IDLE);
   assign req_fire       = req_chan.valid && req_chan.ready;
   assign slot_ok        = int'(req_chan.slot_sel) < SLOTS;
   assign ent_ok         = int'(req_chan.entry_sel) < HISTORY;
   assign slot_new       = SLOT_W'(req_chan.slot_sel);

   assign cmp_addr  = ent_addr(cmp_slot_ff, cmp_ent_ff);
   assign cmp_valid = valid_ff[cmp_addr];
   assign cmp_match = cmp_valid && (q_ff == id_ff);
   assign cmp_last  = (cmp_ent_ff == LAST_ENT) && (!all_ff || cmp_slot_ff == LAST_SLOT);
   assign rd_valid  = valid_ff[ent_addr(slot_ff, ent_ff)];

   assign rsp_chan.valid       = rsp_valid_ff;
   assign rsp_chan.hit         = rsp_hit_ff;
   assign rsp_chan.found_id    = rsp_id_ff;
   assign rsp_chan.found_slot  = rsp_slot_ff;
   assign rsp_chan.found_entry = rsp_ent_ff;

   // sequencer
   always_comb begin
      state_in     = state_ff;
      valid_in     = valid_ff;
      is_slot_in   = is_slot_ff;
      is_ent_in    = is_ent_ff;
      iss_more_in  = iss_more_ff;
      cmp_vld_in   = 1'b0;
      cmp_slot_in  = is_slot_ff;
      cmp_ent_in   = is_ent_ff;
      free_fnd_in  = free_fnd_ff;
      free_ent_in  = free_ent_ff;
      st_ent_in    = st_ent_ff;
      res_hit_in   = res_hit_ff;
      res_id_in    = res_id_ff;
      res_slot_in  = res_slot_ff;
      res_ent_in   = res_ent_ff;
      rd_en        = 1'b0;
      rd_addr      = ent_addr(is_slot_ff, is_ent_ff);
      wr_en        = 1'b0;
      wr_addr      = ent_addr(slot_ff, st_ent_ff);
      wr_data      = id_ff;
      rsp_load     = 1'b0;
      rsp_valid_in = rsp_valid_ff && !rsp_chan.ready;

      // issue one read per cycle while scanning or shifting
      if ((state_ff inside {ST_SCAN, ST_SHIFT}) && iss_more_ff) begin
         rd_en      = 1'b1;
         cmp_vld_in = 1'b1;
         if (is_ent_ff == LAST_ENT) begin
            if (all_ff && is_slot_ff != LAST_SLOT) begin
               is_slot_in = is_slot_ff + SLOT_W'(1);
               is_ent_in  = '0;
            end else begin
               iss_more_in = 1'b0;
            end
         end else begin
            is_ent_in = is_ent_ff + ENT_W'(1);
         end
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               res_hit_in  = 1'b0;
               res_id_in   = '0;
               res_slot_in = '0;
               res_ent_in  = '0;
               is_slot_in  = slot_new;
               is_ent_in   = '0;
               iss_more_in = 1'b0;
               free_fnd_in = 1'b0;
               state_in    = ST_DONE;
               case (req_chan.req_type)
                  REQ_SAVE, REQ_MATCH_SLOT: begin
                     if (slot_ok && req_chan.tag_id_ok) begin
                        iss_more_in = 1'b1;
                        state_in    = ST_SCAN;
                     end
                  end
                  REQ_MATCH_ALL: begin
                     if (req_chan.tag_id_ok) begin
                        is_slot_in  = '0;
                        iss_more_in = 1'b1;
                        state_in    = ST_SCAN;
                     end
                  end
                  REQ_READ: begin
                     if (slot_ok && ent_ok) begin
                        state_in = ST_READ;
                     end
                  end
                  REQ_CLEAR_SLOT: begin
                     if (slot_ok) begin
                        for (int s = 0; s < SLOTS; s++) begin
                           for (int e = 0; e < HISTORY; e++) begin
                              if (SLOT_W'(s) == slot_new) begin
                                 valid_in[s * HISTORY + e] = 1'b0;
                              end
                           end
                        end
                     end
                  end
                  REQ_CLEAR_ALL: begin
                     valid_in = '0;
                  end
                  default: begin
                  end
               endcase
            end
         end

         ST_SCAN: begin
            if (cmp_vld_ff) begin
               // remember the first free entry for a save
               if (!cmp_valid && !free_fnd_ff) begin
                  free_fnd_in = 1'b1;
                  free_ent_in = cmp_ent_ff;
               end
               if (cmp_match) begin
                  iss_more_in = 1'b0;
                  state_in    = ST_DONE;
                  if (op_ff != REQ_SAVE) begin
                     res_hit_in  = 1'b1;
                     res_ent_in  = FOUND_ENTRY_W'(cmp_ent_ff);
                     res_slot_in = all_ff ? FOUND_SLOT_W'(cmp_slot_ff) : '0;
                  end
               end else if (cmp_last) begin
                  iss_more_in = 1'b0;
                  state_in    = ST_DONE;
                  if (op_ff == REQ_SAVE) begin
                     if (free_fnd_ff) begin
                        st_ent_in = free_ent_ff;
                        state_in  = ST_STORE;
                     end else if (!cmp_valid) begin
                        st_ent_in = cmp_ent_ff;
                        state_in  = ST_STORE;
                     end else begin
                        // slot full: move entries down, read from entry one
                        is_slot_in  = slot_ff;
                        is_ent_in   = ENT_W'(1);
                        iss_more_in = 1'b1;
                        state_in    = ST_SHIFT;
                     end
                  end
               end
            end
         end

         ST_SHIFT: begin
            if (cmp_vld_ff) begin
               wr_en   = 1'b1;
               wr_addr = ent_addr(slot_ff, cmp_ent_ff - ENT_W'(1));
               wr_data = q_ff;
               if (cmp_ent_ff == LAST_ENT) begin
                  st_ent_in = LAST_ENT;
                  state_in  = ST_STORE;
               end
            end
         end

         ST_STORE: begin
            wr_en             = 1'b1;
            valid_in[wr_addr] = 1'b1;
            res_hit_in        = 1'b1;
            res_ent_in        = FOUND_ENTRY_W'(st_ent_ff);
            state_in          = ST_DONE;
         end

         ST_READ: begin
            rd_en    = 1'b1;
            rd_addr  = ent_addr(slot_ff, ent_ff);
            state_in = ST_RDATA;
         end

         ST_RDATA: begin
            res_hit_in = rd_valid;
            res_id_in  = rd_valid ? TAG_ID_W'(q_ff) : '0;
            state_in   = ST_DONE;
         end

         ST_DONE: begin
            // hand the result over once the output register is free
            if (!rsp_valid_ff || rsp_chan.ready) begin
               rsp_load     = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         valid_ff     <= '0;
         iss_more_ff  <= 1'b0;
         cmp_vld_ff   <= 1'b0;
         free_fnd_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         valid_ff     <= valid_in;
         iss_more_ff  <= iss_more_in;
         cmp_vld_ff   <= cmp_vld_in;
         free_fnd_ff  <= free_fnd_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      is_slot_ff  <= is_slot_in;
      is_ent_ff   <= is_ent_in;
      cmp_slot_ff <= cmp_slot_in;
      cmp_ent_ff  <= cmp_ent_in;
      free_ent_ff <= free_ent_in;
      st_ent_ff   <= st_ent_in;
      res_hit_ff  <= res_hit_in;
      res_id_ff   <= res_id_in;
      res_slot_ff <= res_slot_in;
      res_ent_ff  <= res_ent_in;
      if (req_fire) begin
         op_ff   <= req_chan.req_type;
         id_ff   <= ID_BITS'(req_chan.tag_id);
         slot_ff <= slot_new;
         ent_ff  <= ENT_W'(req_chan.entry_sel);
         all_ff  <= (req_chan.req_type == REQ_MATCH_ALL);
      end
      if (rsp_load) begin
         rsp_hit_ff  <= res_hit_ff;
         rsp_id_ff   <= res_id_ff;
         rsp_slot_ff <= res_slot_ff;
         rsp_ent_ff  <= res_ent_ff;
      end
   end

   // ID RAM: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         id_mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         q_ff <= id_mem[rd_addr];
      end
   end

`ifndef SYNTHESIS
   // a stored save leaves its entry valid
   a_store_sets_valid: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_STORE) |=> valid_ff[$past(wr_addr)])
      else $error("saved entry not marked valid");

   // clear all empties the table in one step
   a_clear_all_empties: assert property (@(posedge clock) disable iff (reset)
      (req_fire && req_chan.req_type == REQ_CLEAR_ALL) |=> (valid_ff == '0))
      else $error("table not empty after clear all");

   // a finished request reaches the output register and frees the block once the register is free
   a_result_delivered: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DONE && (!rsp_valid_ff || rsp_chan.ready))
      |=> (rsp_valid_ff && state_ff == ST_IDLE))
      else $error("result not loaded into output register");
`endif

endmodule

@@ sim/tag_id_history_store_test.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Tag ID history store testbench
// Sends save, read, match and clear requests through the request channel with
// random idle gaps and result back-pressure. A behavioral copy of the table
// predicts each result, and every result item is checked field by field
// against the oldest pending prediction. A directed part comes first, then
// random traffic built mostly from a small pool of IDs so that slots fill,
// shift and match.
// ----------------------------------------------------------------------------
module tag_id_history_store_test;
   import tids_pkg::*;

   localparam int NUM_SLOTS     = SLOTS_DEF;
   localparam int HIST_DEPTH    = HISTORY_DEF;
   localparam int NUM_ENTRIES   = NUM_SLOTS * HIST_DEPTH;
   localparam int TAG_POOL      = 10;
   localparam int IDLE_LIMIT    = 4000;
   localparam int SETTLE_CYCLES = 2 * NUM_ENTRIES + 8;
   localparam int REPORT_MAX    = 10;

   // request kinds that the store does not know
   localparam logic [REQ_TYPE_W-1:0] REQ_BAD_6 = 3'd6;
   localparam logic [REQ_TYPE_W-1:0] REQ_BAD_7 = 3'd7;

   localparam logic [TAG_ID_W-1:0] ID_ZERO = '0;
   localparam logic [TAG_ID_W-1:0] ID_ONES = '1;
   localparam logic [TAG_ID_W-1:0] ID_A    = 56'h5A_C3_0F_96_E1_24_7B;
   localparam logic [TAG_ID_W-1:0] ID_B    = 56'hA5_3C_F0_69_1E_DB_84;
   localparam logic [TAG_ID_W-1:0] ID_C    = 56'h80_00_00_00_00_00_01;

   typedef struct packed {
      logic [REQ_TYPE_W-1:0]  kind;
      logic [TAG_ID_W-1:0]    tag;
      logic                   ok;
      logic [SLOT_SEL_W-1:0]  slot;
      logic [ENTRY_SEL_W-1:0] entry;
   } tag_req_type;

   typedef struct packed {
      logic                     hit;
      logic [TAG_ID_W-1:0]      id;
      logic [FOUND_SLOT_W-1:0]  slot;
      logic [FOUND_ENTRY_W-1:0] entry;
   } tag_rsp_type;

   logic clock;
   logic reset;
   logic sink_ready = 1'b0;

   tids_req_if req_chan ();
   tids_rsp_if rsp_chan ();

   assign rsp_chan.ready = sink_ready;

   tag_id_history_store dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   // shadow copy of the table
   logic [TAG_ID_W-1:0] shadow_ids [NUM_ENTRIES] = '{default: '0};
   bit                  shadow_valid [NUM_ENTRIES];

   tag_rsp_type         expected_rsps [$];
   tag_rsp_type         rsp_want;
   logic [TAG_ID_W-1:0] tag_pool [TAG_POOL];
   int                  mismatch_count = 0;
   int                  idle_cycles = 0;
   int                  sink_stall = 0;
   bit                  src_idle_en = 1'b0;
   bit                  sink_idle_en = 1'b0;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // gap length: mostly none or short, now and then long
   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 90) return $urandom_range(1, 3);
      if (r < 98) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   // entry of a valid match in one slot, or -1
   function automatic int slot_lookup(int slot, logic [TAG_ID_W-1:0] tag);
      int k;
      for (k = 0; k < HIST_DEPTH; k++) begin
         if (shadow_valid[slot * HIST_DEPTH + k] && shadow_ids[slot * HIST_DEPTH + k] == tag)
            return k;
      end
      return -1;
   endfunction

   // apply one request to the shadow table and return its result
   function automatic tag_rsp_type store_apply(tag_req_type r);
      tag_rsp_type rsp;
      int          base;
      int          pos;
      int          m;
      int          k;
      bit          slot_in;
      rsp = '0;
      slot_in = int'(r.slot) < NUM_SLOTS;
      base = int'(r.slot) * HIST_DEPTH;
      case (r.kind)
         REQ_SAVE: begin
            if (slot_in && r.ok && slot_lookup(int'(r.slot), r.tag) < 0) begin
               pos = HIST_DEPTH;
               for (k = HIST_DEPTH - 1; k >= 0; k--)
                  if (!shadow_valid[base + k]) pos = k;
               // full slot: shift the history down, newest goes last
               if (pos == HIST_DEPTH) begin
                  for (k = 0; k < HIST_DEPTH - 1; k++) begin
                     shadow_ids[base + k]   = shadow_ids[base + k + 1];
                     shadow_valid[base + k] = shadow_valid[base + k + 1];
                  end
                  pos = HIST_DEPTH - 1;
               end
               shadow_ids[base + pos]   = r.tag;
               shadow_valid[base + pos] = 1'b1;
               rsp.hit   = 1'b1;
               rsp.entry = FOUND_ENTRY_W'(pos);
            end
         end
         REQ_READ: begin
            if (slot_in && int'(r.entry) < HIST_DEPTH && shadow_valid[base + r.entry]) begin
               rsp.hit = 1'b1;
               rsp.id  = shadow_ids[base + r.entry];
            end
         end
         REQ_MATCH_SLOT: begin
            if (slot_in && r.ok) begin
               m = slot_lookup(int'(r.slot), r.tag);
               if (m >= 0) begin
                  rsp.hit   = 1'b1;
                  rsp.entry = FOUND_ENTRY_W'(m);
               end
            end
         end
         REQ_MATCH_ALL: begin
            // scan downward so the lowest index wins
            if (r.ok) begin
               for (k = NUM_ENTRIES - 1; k >= 0; k--) begin
                  if (shadow_valid[k] && shadow_ids[k] == r.tag) begin
                     rsp.hit   = 1'b1;
                     rsp.slot  = FOUND_SLOT_W'(k / HIST_DEPTH);
                     rsp.entry = FOUND_ENTRY_W'(k % HIST_DEPTH);
                  end
               end
            end
         end
         REQ_CLEAR_SLOT: begin
            if (slot_in) begin
               for (k = 0; k < HIST_DEPTH; k++) begin
                  shadow_ids[base + k]   = '0;
                  shadow_valid[base + k] = 1'b0;
               end
            end
         end
         REQ_CLEAR_ALL: begin
            for (k = 0; k < NUM_ENTRIES; k++) begin
               shadow_ids[k]   = '0;
               shadow_valid[k] = 1'b0;
            end
         end
         default: ;
      endcase
      return rsp;
   endfunction

   function automatic tag_req_type mk_req(logic [REQ_TYPE_W-1:0] kind,
                                          logic [TAG_ID_W-1:0] tag,
                                          logic ok, int slot, int entry);
      tag_req_type r;
      r.kind  = kind;
      r.tag   = tag;
      r.ok    = ok;
      r.slot  = SLOT_SEL_W'(slot);
      r.entry = ENTRY_SEL_W'(entry);
      return r;
   endfunction

   task automatic check_field(string name, logic [63:0] want, logic [63:0] got);
      if (got !== want) begin
         mismatch_count++;
         if (mismatch_count <= REPORT_MAX)
            $display("%0t: %s mismatch, expected %h, got %h", $time, name, want, got);
      end
   endtask

   // send one item, record its prediction once it is accepted
   task automatic send_item(tag_req_type r);
      int gap;
      gap = src_idle_en ? pick_gap() : 0;
      if (gap > 0) begin
         req_chan.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_chan.req_type  <= r.kind;
      req_chan.tag_id    <= r.tag;
      req_chan.tag_id_ok <= r.ok;
      req_chan.slot_sel  <= r.slot;
      req_chan.entry_sel <= r.entry;
      req_chan.valid     <= 1'b1;
      do @(posedge clock); while (req_chan.ready !== 1'b1);
      expected_rsps.push_back(store_apply(r));
   endtask

   // hold off the sender until every pending result is in
   task automatic wait_for_results();
      req_chan.valid <= 1'b0;
      while (expected_rsps.size() != 0) @(posedge clock);
   endtask

   // check each result item against the oldest prediction
   always @(posedge clock) begin
      if (!reset && rsp_chan.valid === 1'b1 && sink_ready) begin
         if (expected_rsps.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= REPORT_MAX)
               $display("%0t: result item with none pending", $time);
         end else begin
            rsp_want = expected_rsps.pop_front();
            check_field("hit", 64'(rsp_want.hit), 64'(rsp_chan.hit));
            check_field("found_id", 64'(rsp_want.id), 64'(rsp_chan.found_id));
            check_field("found_slot", 64'(rsp_want.slot), 64'(rsp_chan.found_slot));
            check_field("found_entry", 64'(rsp_want.entry), 64'(rsp_chan.found_entry));
         end
      end
   end

   // result back-pressure
   always @(posedge clock) begin
      if (sink_stall > 0) begin
         sink_stall <= sink_stall - 1;
         sink_ready <= 1'b0;
      end else begin
         sink_ready <= 1'b1;
         if (sink_idle_en) sink_stall <= pick_gap();
      end
   end

   // end the run when nothing moves for too long
   always @(posedge clock) begin
      if (reset || (req_chan.valid && req_chan.ready) || (rsp_chan.valid && sink_ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
         $display("%0t: no item moved for %0d cycles", $time, IDLE_LIMIT);
         $display("TEST FAILED");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   // empty table: reads find nothing, a zero ID matches nothing
   task automatic test_reset_view();
      send_item(mk_req(REQ_READ, ID_ONES, 1'b1, 0, 0));
      send_item(mk_req(REQ_READ, ID_ZERO, 1'b0, 3, 3));
      send_item(mk_req(REQ_MATCH_ALL, ID_ZERO, 1'b1, 0, 0));
   endtask

   // fill a slot, drop a duplicate and an invalid ID, then overflow it
   task automatic test_save_history();
      send_item(mk_req(REQ_SAVE, ID_ONES, 1'b1, 1, 0));
      send_item(mk_req(REQ_SAVE, ID_ZERO, 1'b1, 1, 3));
      send_item(mk_req(REQ_SAVE, ID_A, 1'b1, 1, 0));
      send_item(mk_req(REQ_SAVE, ID_B, 1'b1, 1, 0));
      send_item(mk_req(REQ_SAVE, ID_ONES, 1'b1, 1, 0));
      send_item(mk_req(REQ_SAVE, ID_C, 1'b0, 1, 0));
      send_item(mk_req(REQ_SAVE, ID_C, 1'b1, 1, 0));
      send_item(mk_req(REQ_READ, ID_ZERO, 1'b0, 1, 0));
      send_item(mk_req(REQ_READ, ID_ONES, 1'b1, 1, 3));
   endtask

   // slot match, global match with several hits, invalid IDs
   task automatic test_matching();
      send_item(mk_req(REQ_MATCH_SLOT, ID_C, 1'b1, 1, 0));
      send_item(mk_req(REQ_MATCH_SLOT, ID_C, 1'b0, 1, 0));
      send_item(mk_req(REQ_SAVE, ID_ONES, 1'b1, 2, 0));
      send_item(mk_req(REQ_MATCH_ALL, ID_ONES, 1'b1, 0, 0));
      send_item(mk_req(REQ_SAVE, ID_ZERO, 1'b1, 0, 0));
      send_item(mk_req(REQ_MATCH_ALL, ID_ZERO, 1'b1, 3, 3));
      send_item(mk_req(REQ_MATCH_ALL, ID_ZERO, 1'b0, 0, 0));
   endtask

   // unknown kinds change nothing; clears empty a slot and the table
   task automatic test_clear_and_unknown();
      send_item(mk_req(REQ_BAD_6, ID_ONES, 1'b1, 1, 3));
      send_item(mk_req(REQ_BAD_7, ID_ONES, 1'b1, 3, 3));
      send_item(mk_req(REQ_CLEAR_SLOT, ID_ONES, 1'b1, 1, 3));
      send_item(mk_req(REQ_READ, ID_ZERO, 1'b1, 1, 0));
      send_item(mk_req(REQ_CLEAR_ALL, ID_ONES, 1'b1, 3, 3));
      send_item(mk_req(REQ_MATCH_ALL, ID_ZERO, 1'b1, 0, 0));
   endtask

   function automatic logic [TAG_ID_W-1:0] random_tag();
      return TAG_ID_W'({$urandom, $urandom});
   endfunction

   // pool IDs most of the time so slots fill, shift and match
   function automatic logic [TAG_ID_W-1:0] pick_tag();
      int r;
      r = $urandom_range(0, 99);
      if (r < 75) return tag_pool[$urandom_range(0, TAG_POOL - 1)];
      if (r < 85) return random_tag();
      if (r < 89) return ID_ONES;
      if (r < 93) return ID_ZERO;
      return tag_pool[$urandom_range(0, TAG_POOL - 1)] ^ (TAG_ID_W'(1) << $urandom_range(0, 55));
   endfunction

   function automatic tag_req_type random_req();
      tag_req_type r;
      int          w;
      w = $urandom_range(0, 99);
      if (w < 36)      r.kind = REQ_SAVE;
      else if (w < 54) r.kind = REQ_READ;
      else if (w < 72) r.kind = REQ_MATCH_SLOT;
      else if (w < 92) r.kind = REQ_MATCH_ALL;
      else if (w < 97) r.kind = REQ_CLEAR_SLOT;
      else if (w < 98) r.kind = REQ_CLEAR_ALL;
      else             r.kind = $urandom_range(0, 1) ? REQ_BAD_6 : REQ_BAD_7;
      r.tag   = pick_tag();
      r.ok    = $urandom_range(0, 99) < 92;
      r.slot  = SLOT_SEL_W'($urandom_range(0, 3));
      r.entry = ENTRY_SEL_W'($urandom_range(0, 3));
      return r;
   endfunction

   // random traffic in phases of varying idling, some drained at the end
   task automatic test_random_traffic(int total);
      int          sent;
      int          burst;
      int          i;
      bit          first;
      tag_req_type r;
      sent = 0;
      first = 1'b1;
      for (i = 0; i < TAG_POOL; i++) tag_pool[i] = random_tag();
      while (sent < total) begin
         src_idle_en  = !first && $urandom_range(0, 3) != 0;
         sink_idle_en = !first && $urandom_range(0, 3) != 0;
         first = 1'b0;
         tag_pool[$urandom_range(0, TAG_POOL - 1)] = random_tag();
         burst = $urandom_range(60, 180);
         for (i = 0; i < burst && sent < total; i++) begin
            r = random_req();
            send_item(r);
            if (!(r.kind inside {REQ_BAD_6, REQ_BAD_7})) sent++;
         end
         if ($urandom_range(0, 2) == 0) wait_for_results();
      end
   endtask

   initial begin
      req_chan.valid     <= 1'b0;
      req_chan.req_type  <= REQ_SAVE;
      req_chan.tag_id    <= '0;
      req_chan.tag_id_ok <= 1'b0;
      req_chan.slot_sel  <= '0;
      req_chan.entry_sel <= '0;
      reset              <= 1'b1;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      test_reset_view();
      wait_for_results();
      test_save_history();
      src_idle_en  = 1'b1;
      sink_idle_en = 1'b1;
      test_matching();
      wait_for_results();
      test_clear_and_unknown();
      wait_for_results();
      test_random_traffic(850);

      // drain, then give stray results time to show up
      wait_for_results();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (expected_rsps.size() != 0)
         $display("%0d result items never arrived", expected_rsps.size());
      if (mismatch_count == 0 && expected_rsps.size() == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule
